### rtl/button_autorepeat_adjuster_core_macros.svh
// Assertion macros shared by the button auto-repeat adjuster RTL.
// Self-contained; included by the modules that carry checks.
`ifndef BUTTON_AUTOREPEAT_ADJUSTER_CORE_MACROS_SVH
`define BUTTON_AUTOREPEAT_ADJUSTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BAR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bar assertion failed");

// Next-cycle implication, checked outside reset.
`define BAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bar assertion failed");

`endif

### rtl/bar_pkg.sv
// Shared types, constants and helpers of the button auto-repeat adjuster.
// No dependencies; used by every RTL module of the block.
package bar_pkg;

	localparam int unsigned ValW   = 16;
	localparam int unsigned CntW   = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 24;

	// Input tdata bit positions
	localparam int unsigned UpLevelBit   = 0;
	localparam int unsigned DownLevelBit = 1;
	localparam int unsigned EscLevelBit  = 2;
	localparam int unsigned UpClickBit   = 3;
	localparam int unsigned DownClickBit = 4;
	localparam int unsigned ExitAckBit   = 5;
	localparam int unsigned LoadLsb      = 6;

	localparam logic [ValW-1:0] MaxValueRst       = 16'd999;
	localparam logic [CntW-1:0] InitialDelayRst   = 16'd500;
	localparam logic [CntW-1:0] RepeatIntervalRst = 16'd50;
	localparam logic [CntW-1:0] LongPressTimeRst  = 16'd2000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_VALUE       = 2'd0,
		REG_INITIAL_DELAY   = 2'd1,
		REG_REPEAT_INTERVAL = 2'd2,
		REG_LONG_PRESS_TIME = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [ValW-1:0] max_value;
		logic [CntW-1:0] initial_delay;
		logic [CntW-1:0] repeat_interval;
		logic [CntW-1:0] long_press_time;
	} cfg_t;

	typedef struct packed {
		logic            command;
		logic            up_level;
		logic            down_level;
		logic            esc_level;
		logic            up_click;
		logic            down_click;
		logic            exit_ack;
		logic [ValW-1:0] load_value;
	} item_t;

	typedef struct packed {
		logic [ValW-1:0] value;
		logic            exit_request;
	} res_t;

	// Counter increment that sticks at all ones.
	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (v == '1) ? v : v + CntW'(1);
	endfunction

endpackage

### rtl/bar_cfg_regs.sv
// Configuration register file of the button auto-repeat adjuster.
// Depends on bar_pkg for the register index codes and the cfg_t bundle.
module bar_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bar_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bar_pkg::CntW-1:0]     cfg_data,
	output bar_pkg::cfg_t                cfg
);

	bar_pkg::cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_value       <= bar_pkg::MaxValueRst;
			cfg_q.initial_delay   <= bar_pkg::InitialDelayRst;
			cfg_q.repeat_interval <= bar_pkg::RepeatIntervalRst;
			cfg_q.long_press_time <= bar_pkg::LongPressTimeRst;
		end else if (cfg_valid) begin
			case (bar_pkg::cfg_idx_t'(cfg_index))
				bar_pkg::REG_MAX_VALUE:       cfg_q.max_value       <= cfg_data;
				bar_pkg::REG_INITIAL_DELAY:   cfg_q.initial_delay   <= cfg_data;
				bar_pkg::REG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_data;
				bar_pkg::REG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/bar_update.sv
// State registers and per-word update logic of the button auto-repeat adjuster.
// Depends on bar_pkg and the assertion macro header.
`include "button_autorepeat_adjuster_core_macros.svh"

module bar_update (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  bar_pkg::item_t item,
	input  bar_pkg::cfg_t  cfg,
	output bar_pkg::res_t  result
);

	logic [bar_pkg::ValW-1:0] value_q;
	logic [bar_pkg::CntW-1:0] hold_ticks_q;
	logic [bar_pkg::CntW-1:0] repeat_ticks_q;
	logic [bar_pkg::CntW-1:0] esc_ticks_q;
	logic                     esc_held_q;
	logic                     exit_flag_q;

	logic [bar_pkg::ValW-1:0] value_d;
	logic [bar_pkg::CntW-1:0] hold_ticks_d;
	logic [bar_pkg::CntW-1:0] repeat_ticks_d;
	logic [bar_pkg::CntW-1:0] esc_ticks_d;
	logic                     esc_held_d;
	logic                     exit_flag_d;

	logic                     up_p;
	logic                     dn_p;
	logic                     esc_p;
	logic                     rep_hit;
	logic                     up_step;
	logic                     dn_step;
	logic                     alone;
	logic [bar_pkg::ValW-1:0] v_click_up;
	logic [bar_pkg::ValW-1:0] v_click_dn;
	logic [bar_pkg::ValW-1:0] v_rep_up;
	logic [bar_pkg::CntW-1:0] rep_mid;
	logic [bar_pkg::CntW-1:0] esc_mid;
	logic                     esc_held_mid;

	assign up_p  = !item.up_level;
	assign dn_p  = !item.down_level;
	assign esc_p = !item.esc_level;

	// Clicks first, then the hold polls; up wins the shared repeat counter.
	assign rep_hit = repeat_ticks_q > cfg.repeat_interval;
	assign up_step = up_p && rep_hit;

	assign v_click_up = (item.up_click && value_q < cfg.max_value) ?
		value_q + bar_pkg::ValW'(1) : value_q;
	assign v_click_dn = (item.down_click && v_click_up != '0) ?
		v_click_up - bar_pkg::ValW'(1) : v_click_up;
	assign v_rep_up = (up_step && v_click_dn < cfg.max_value) ?
		v_click_dn + bar_pkg::ValW'(1) : v_click_dn;
	assign dn_step = dn_p && !up_p && rep_hit && v_rep_up != '0;

	assign rep_mid = (up_step || dn_step) ? '0 : repeat_ticks_q;

	assign alone = esc_p && !up_p && !dn_p && !item.up_click && !item.down_click;

	always_comb begin
		exit_flag_d    = item.exit_ack ? 1'b0 : exit_flag_q;
		value_d        = value_q;
		hold_ticks_d   = hold_ticks_q;
		repeat_ticks_d = repeat_ticks_q;
		esc_ticks_d    = esc_ticks_q;
		esc_held_d     = esc_held_q;
		esc_mid        = esc_ticks_q;
		esc_held_mid   = esc_held_q;
		if (item.command) begin
			value_d = item.load_value;
		end else begin
			value_d = dn_step ? v_rep_up - bar_pkg::ValW'(1) : v_rep_up;

			// Escape poll, against the flag as left by the acknowledge.
			if (alone) begin
				if (!exit_flag_d) begin
					if (esc_ticks_q > cfg.long_press_time) begin
						exit_flag_d  = 1'b1;
						esc_mid      = '0;
						esc_held_mid = 1'b0;
					end else begin
						esc_held_mid = 1'b1;
					end
				end
			end else begin
				esc_mid      = '0;
				esc_held_mid = 1'b0;
			end
			esc_held_d  = esc_held_mid;
			esc_ticks_d = esc_held_mid ? bar_pkg::sat_inc(esc_mid) : esc_mid;

			// Tick counters advance after the polls.
			if (up_p || dn_p) begin
				hold_ticks_d   = bar_pkg::sat_inc(hold_ticks_q);
				repeat_ticks_d = rep_mid;
			end else begin
				hold_ticks_d   = '0;
				repeat_ticks_d = '0;
			end
			if (hold_ticks_d > cfg.initial_delay)
				repeat_ticks_d = bar_pkg::sat_inc(repeat_ticks_d);
		end
	end

	assign result.value        = value_d;
	assign result.exit_request = exit_flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q        <= '0;
			hold_ticks_q   <= '0;
			repeat_ticks_q <= '0;
			esc_ticks_q    <= '0;
			esc_held_q     <= 1'b0;
			exit_flag_q    <= 1'b0;
		end else if (advance) begin
			value_q        <= value_d;
			hold_ticks_q   <= hold_ticks_d;
			repeat_ticks_q <= repeat_ticks_d;
			esc_ticks_q    <= esc_ticks_d;
			esc_held_q     <= esc_held_d;
			exit_flag_q    <= exit_flag_d;
		end
	end

	// A running escape count always has the held mark behind it.
	`BAR_ASSERT_IMPLIES(a_esc_cnt_held, clk, arst_n, esc_ticks_q != '0, esc_held_q)
	// Repeat counting only happens during a hold.
	`BAR_ASSERT_IMPLIES(a_rep_needs_hold, clk, arst_n, hold_ticks_q == '0,
		repeat_ticks_q == '0)
	// A load leaves the hold counter alone.
	`BAR_ASSERT_NEXT(a_load_keeps_hold, clk, arst_n, advance && item.command,
		$stable(hold_ticks_q))

endmodule

### rtl/button_autorepeat_adjuster_core.sv
// Button auto-repeat adjuster, top level: stream ports, input and output stages.
// Depends on bar_pkg, bar_cfg_regs, bar_update and the assertion macro header.
//
// Usage:
//   Each input word is either a 1 ms tick (s_tuser = 0) carrying the active-low
//   up, down and escape pin levels, single-click pulses and an exit acknowledge,
//   or a load (s_tuser = 1) that sets the adjusted value from load_value.
//   Every accepted word yields exactly one output word with the adjusted value
//   and the exit request flag as they stand after that word.
//   Path: an accepted word is registered in the input stage; its result is then
//   registered in the output stage and driven on m_tvalid/m_tdata (two-register path).
//   Throughput: one word per clock while m_tready is high; the state update is a
//   single pass of compare/increment logic between input stage and output register.
//   Stall: if m_tready stays low, the output register holds its word, the input
//   stage fills, and s_tready drops; nothing is dropped or repeated.
//   Configuration: cfg_index selects max_value (0), initial_delay (1),
//   repeat_interval (2) or long_press_time (3); writes always complete
//   (cfg_ready is tied high) and are meant for idle periods only.
//   Reset: arst_n clears the value, all tick counters and the exit flag, empties
//   both stages and restores the register defaults 999, 500, 50 and 2000.
`include "button_autorepeat_adjuster_core_macros.svh"

module button_autorepeat_adjuster_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tdata: up_level, down_level, esc_level, up_click, down_click, exit_ack,
	//        load_value[15:0], zero pad
	input  logic [bar_pkg::InDataW-1:0]    s_tdata,
	// tuser: command
	input  logic                           s_tuser,
	// Output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// tdata: value[15:0], exit_request, zero pad
	output logic [bar_pkg::OutDataW-1:0]   m_tdata,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bar_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bar_pkg::CntW-1:0]       cfg_data
);

	bar_pkg::cfg_t  cfg;
	bar_pkg::item_t item_in;
	bar_pkg::item_t item_s1;
	bar_pkg::res_t  res_next;
	bar_pkg::res_t  res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           s_accept;
	logic           advance;

	// Unpack the input word into named fields.
	assign item_in.command    = s_tuser;
	assign item_in.up_level   = s_tdata[bar_pkg::UpLevelBit];
	assign item_in.down_level = s_tdata[bar_pkg::DownLevelBit];
	assign item_in.esc_level  = s_tdata[bar_pkg::EscLevelBit];
	assign item_in.up_click   = s_tdata[bar_pkg::UpClickBit];
	assign item_in.down_click = s_tdata[bar_pkg::DownClickBit];
	assign item_in.exit_ack   = s_tdata[bar_pkg::ExitAckBit];
	assign item_in.load_value = s_tdata[bar_pkg::LoadLsb +: bar_pkg::ValW];

	// Advance the input stage whenever the output register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	bar_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bar_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_next)
	);

	// Input stage: hold the word until the update consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_in;
		end
	end

	// Output register: hold the result while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(bar_pkg::OutDataW - bar_pkg::ValW - 1)'(0),
		res_s2.exit_request, res_s2.value};

	// A full pipe facing a stalled receiver must push back.
	`BAR_ASSERT_IMPLIES(a_backpressure, clk, arst_n, valid_s1 && valid_s2 && !m_tready,
		!s_tready)
	// An accepted word lands in the input stage.
	`BAR_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_accept, valid_s1)
	// A consumed word shows up in the output register.
	`BAR_ASSERT_NEXT(a_advance_fills_s2, clk, arst_n, advance, valid_s2)

endmodule
